[hw/rtl/snsc_pkg.sv]
package snsc_pkg;

    // default name length
    localparam int NAME_LEN_DEF = 16;

    // protocol characters
    localparam logic [7:0] CH_START = 8'h4E;  // 'N'
    localparam logic [7:0] CH_WRITE = 8'h3D;  // '='
    localparam logic [7:0] CH_READ  = 8'h3F;  // '?'

    // CRC-8, reflected
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // status codes
    localparam logic [1:0] ST_BAD_CMD  = 2'd0;
    localparam logic [1:0] ST_WRITTEN  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_READ     = 2'd3;

    // output register source select
    localparam logic [1:0] SEL_NONE   = 2'd0;
    localparam logic [1:0] SEL_NAME   = 2'd1;
    localparam logic [1:0] SEL_HEX_HI = 2'd2;
    localparam logic [1:0] SEL_HEX_LO = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic       clr;        // clear byte count and CRC
        logic       name_wr;    // store rx byte, fold into CRC, count up
        logic       hex1_wr;    // keep first CRC digit
        logic       commit;     // swap banks, received name becomes stored name
        logic       rd_en;      // read stored name at byte count
        logic       rd_step;    // fold read byte into CRC, count up
        logic       out_load;   // load output register
        logic [1:0] out_sel;
        logic       out_stat_v;
        logic [1:0] out_stat;
        logic       out_last;
    } snsc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_start;
        logic is_write;
        logic is_read;
        logic name_done;   // byte count at final name byte
        logic crc_match;   // received CRC equals computed CRC
        logic crc_hi;      // CRC needs two hex characters
        logic out_free;    // output register can take a beat
    } snsc_sts_t;

    // one byte through the CRC-8, bit by bit, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] b);
        logic [7:0] c;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // hex character value, bit 4 set when not a hex character
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 5'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 5'(c - 8'h57);
        else
            v = 5'd16;
        return v;
    endfunction

    // uppercase hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10)
            c = 8'h30 + {4'b0, v};
        else
            c = 8'h37 + {4'b0, v};
        return c;
    endfunction

endpackage

[hw/rtl/serial_name_store_with_crc8.sv]
// Acceptance: a hunt, name or CRC byte is taken while the sequencer is idle; a status
//   beat is loaded into the output register from S_STAT or S_HEX2, later while the output stalls.
// Hold-off: a read command byte holds off the next accept while the sequencer steps
//   through S_RD_ADDR and S_RD_EMIT per name byte (the memory read is registered), then
//   S_HEX1 and S_HEX2, S_HEX1 spent even when the high digit is dropped; a status-only
//   command byte holds it off through S_STAT; longer while the output stalls.
// Reset: asynchronous, active low; control returns to hunting, the stored name reads
//   as all zeros until the first good write. No clearing pass.
module serial_name_store_with_crc8
    import snsc_pkg::*;
#(
    parameter int NAME_LEN = NAME_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       status_valid,
    output logic [1:0] status,
    output logic       last
);

    snsc_cmd_t cmd;
    snsc_sts_t sts;

    snsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    snsc_dp #(
        .NAME_LEN (NAME_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .rx_byte      (rx_byte),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .tx_valid     (tx_valid),
        .tx_byte      (tx_byte),
        .status_valid (status_valid),
        .status       (status)
        , .last       (last)
    );

    // a beat in the output register is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output register overwritten");

    // name store only changes on a matching CRC
    a_commit_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (sts.crc_match && in_valid && !in_stall))
        else $error("commit without CRC match");

    // every status beat closes its input beat's results
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_valid) |-> last)
        else $error("status beat not marked last");

    // no new input beat while a read command is still emitting
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en || cmd.rd_step) |-> in_stall)
        else $error("input taken during read sweep");

endmodule

[hw/rtl/snsc_dp.sv]
module snsc_dp
    import snsc_pkg::*;
#(
    parameter int NAME_LEN = NAME_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  snsc_cmd_t  cmd,
    output snsc_sts_t  sts,
    input  logic [7:0] rx_byte,
    input  logic       out_stall,
    output logic       out_valid,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       status_valid,
    output logic [1:0] status,
    output logic       last
);

    localparam int IDX_W = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
    localparam int ADR_W = IDX_W + 1;
    localparam int DEPTH = 2 << IDX_W;

    // two banks: one holds the stored name, the other takes the name being received
    logic [7:0]       mem [DEPTH];
    logic [7:0]       rd_data_reg;
    logic             bank_reg, bank_next;
    logic             stored_reg, stored_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [7:0]       crc_reg, crc_next;
    logic [4:0]       hex1_reg;

    logic             out_valid_reg, out_valid_next;
    logic             tx_valid_reg;
    logic [7:0]       tx_byte_reg;
    logic             status_valid_reg;
    logic [1:0]       status_reg;
    logic             last_reg;

    logic [7:0]       name_byte;
    logic [4:0]       hex2;
    logic [7:0]       rx_crc;

    // stored name reads as zero until the first good write
    assign name_byte = stored_reg ? rd_data_reg : 8'h00;

    // received CRC: two hex digits, a non-hex character ends the number
    assign hex2 = hex_value(rx_byte);
    always_comb
    begin
        if (hex1_reg[4])
            rx_crc = 8'h00;
        else if (hex2[4])
            rx_crc = {4'b0, hex1_reg[3:0]};
        else
            rx_crc = {hex1_reg[3:0], hex2[3:0]};
    end

    // status back to controller
    assign sts.is_start  = (rx_byte == CH_START);
    assign sts.is_write  = (rx_byte == CH_WRITE);
    assign sts.is_read   = (rx_byte == CH_READ);
    assign sts.name_done = (count_reg == IDX_W'(NAME_LEN - 1));
    assign sts.crc_match = (rx_crc == crc_reg);
    assign sts.crc_hi    = (crc_reg[7:4] != 4'h0);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // name memory
    always_ff @(posedge clk)
    begin
        if (cmd.name_wr)
            mem[{~bank_reg, count_reg}] <= rx_byte;
        if (cmd.rd_en)
            rd_data_reg <= mem[ADR_W'({bank_reg, count_reg})];
    end

    // count, CRC and bank control
    always_comb
    begin
        count_next  = count_reg;
        crc_next    = crc_reg;
        bank_next   = bank_reg;
        stored_next = stored_reg;
        if (cmd.clr)
        begin
            count_next = '0;
            crc_next   = 8'h00;
        end
        else if (cmd.name_wr)
        begin
            count_next = count_reg + IDX_W'(1);
            crc_next   = crc8_byte(crc_reg, rx_byte);
        end
        else if (cmd.rd_step)
        begin
            count_next = count_reg + IDX_W'(1);
            crc_next   = crc8_byte(crc_reg, name_byte);
        end
        if (cmd.commit)
        begin
            bank_next   = ~bank_reg;
            stored_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            crc_reg    <= 8'h00;
            bank_reg   <= 1'b0;
            stored_reg <= 1'b0;
            hex1_reg   <= 5'd0;
        end
        else
        begin
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            bank_reg   <= bank_next;
            stored_reg <= stored_next;
            if (cmd.hex1_wr)
                hex1_reg <= hex2;
        end
    end

    // output register
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_valid_reg <= cmd.out_stat_v;
            status_reg       <= cmd.out_stat_v ? cmd.out_stat : 2'd0;
            last_reg         <= cmd.out_last;
            unique case (cmd.out_sel)
                SEL_NAME:
                begin
                    tx_valid_reg <= 1'b1;
                    tx_byte_reg  <= name_byte;
                end
                SEL_HEX_HI:
                begin
                    tx_valid_reg <= 1'b1;
                    tx_byte_reg  <= hex_char(crc_reg[7:4]);
                end
                SEL_HEX_LO:
                begin
                    tx_valid_reg <= 1'b1;
                    tx_byte_reg  <= hex_char(crc_reg[3:0]);
                end
                default:
                begin
                    tx_valid_reg <= 1'b0;
                    tx_byte_reg  <= 8'h00;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign tx_valid     = tx_valid_reg;
    assign tx_byte      = tx_byte_reg;
    assign status_valid = status_valid_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

[hw/rtl/snsc_ctrl.sv]
module snsc_ctrl
    import snsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  snsc_sts_t sts,
    output snsc_cmd_t cmd
);

    // protocol phase
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_CMD  = 3'd1;
    localparam logic [2:0] PH_NAME = 3'd2;
    localparam logic [2:0] PH_CRC1 = 3'd3;
    localparam logic [2:0] PH_CRC2 = 3'd4;

    // sequencer state
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RD_ADDR = 3'd1;
    localparam logic [2:0] S_RD_EMIT = 3'd2;
    localparam logic [2:0] S_HEX1    = 3'd3;
    localparam logic [2:0] S_HEX2    = 3'd4;
    localparam logic [2:0] S_STAT    = 3'd5;

    logic [2:0] phase_reg, phase_next;
    logic [2:0] state_reg, state_next;
    logic [1:0] stat_reg, stat_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        phase_next = phase_reg;
        state_next = state_reg;
        stat_next  = stat_reg;
        cmd        = '0;
        unique case (state_reg)
            // one input beat, dispatched on the protocol phase
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (sts.is_start)
                                phase_next = PH_CMD;
                        end
                        PH_CMD:
                        begin
                            if (sts.is_write)
                            begin
                                cmd.clr    = 1'b1;
                                phase_next = PH_NAME;
                            end
                            else
                            begin
                                phase_next = PH_HUNT;
                                if (sts.is_read)
                                begin
                                    cmd.clr    = 1'b1;
                                    state_next = S_RD_ADDR;
                                end
                                else
                                begin
                                    stat_next  = ST_BAD_CMD;
                                    state_next = S_STAT;
                                end
                            end
                        end
                        PH_NAME:
                        begin
                            cmd.name_wr = 1'b1;
                            if (sts.name_done)
                                phase_next = PH_CRC1;
                        end
                        PH_CRC1:
                        begin
                            cmd.hex1_wr = 1'b1;
                            phase_next  = PH_CRC2;
                        end
                        PH_CRC2:
                        begin
                            phase_next = PH_HUNT;
                            state_next = S_STAT;
                            if (sts.crc_match)
                            begin
                                cmd.commit = 1'b1;
                                stat_next  = ST_WRITTEN;
                            end
                            else
                                stat_next = ST_MISMATCH;
                        end
                        default:
                            phase_next = PH_HUNT;
                    endcase
                end
            end
            // read sweep: address, then emit the byte
            S_RD_ADDR:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_RD_EMIT;
            end
            S_RD_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_NAME;
                    cmd.rd_step  = 1'b1;
                    state_next   = sts.name_done ? S_HEX1 : S_RD_ADDR;
                end
            end
            // high CRC digit only when nonzero
            S_HEX1:
            begin
                if (!sts.crc_hi)
                    state_next = S_HEX2;
                else if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_HEX_HI;
                    state_next   = S_HEX2;
                end
            end
            S_HEX2:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = SEL_HEX_LO;
                    cmd.out_stat_v = 1'b1;
                    cmd.out_stat   = ST_READ;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            // status-only beat
            S_STAT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = SEL_NONE;
                    cmd.out_stat_v = 1'b1;
                    cmd.out_stat   = stat_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            state_reg <= S_IDLE;
            stat_reg  <= ST_BAD_CMD;
        end
        else
        begin
            phase_reg <= phase_next;
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

endmodule
